@@ sv/gspg_pkg.sv @@
// gspg_pkg: shared types, constants and the sweep and deadband helper
// functions for the gimbal setpoint patrol generator
// no dependencies
package gspg_pkg;

    // angle units are 1/64 degree
    localparam int unsigned ANGLE_W  = 15;
    localparam int unsigned TARGET_W = 16;
    localparam int unsigned BAND_W   = 8;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic signed [TARGET_W-1:0] HALF_TURN = 16'sd11520;
    localparam logic signed [TARGET_W-1:0] FULL_TURN = 16'sd23040;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_YAW_DEADBAND     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_DEADBAND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_HIGH_FREE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_LOW_FREE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_HIGH_TRACK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_LOW_TRACK    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_HIGH_TRACK = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_LOW_TRACK  = 3'd7;

    // configuration reset values
    localparam logic signed [ANGLE_W-1:0] PITCH_HIGH_FREE_RST  = 15'sd2240;
    localparam logic signed [ANGLE_W-1:0] PITCH_LOW_FREE_RST   = 15'sd640;
    localparam logic signed [ANGLE_W-1:0] YAW_HIGH_TRACK_RST   = 15'sd5120;
    localparam logic signed [ANGLE_W-1:0] YAW_LOW_TRACK_RST    = -15'sd1280;
    localparam logic signed [ANGLE_W-1:0] PITCH_HIGH_TRACK_RST = 15'sd2560;
    localparam logic signed [ANGLE_W-1:0] PITCH_LOW_TRACK_RST  = 15'sd256;

    typedef struct packed {
        logic signed [TARGET_W-1:0] target;
        logic                       down;
    } sweep_res_t;

    // one sweep step: rise toward high unless descending, then (same tick) fall toward low if descending
    function automatic sweep_res_t sweep(
        input logic signed [ANGLE_W-1:0] meas,
        input logic signed [ANGLE_W-1:0] cmd,
        input logic signed [ANGLE_W-1:0] hi,
        input logic signed [ANGLE_W-1:0] lo,
        input logic                      down
    );
        logic signed [TARGET_W-1:0] m16;
        logic signed [TARGET_W-1:0] c16;
        logic signed [TARGET_W-1:0] h16;
        logic signed [TARGET_W-1:0] l16;
        logic signed [TARGET_W-1:0] t;
        logic                       d;
        sweep_res_t                 res;
        m16 = {meas[ANGLE_W-1], meas};
        c16 = {cmd[ANGLE_W-1], cmd};
        h16 = {hi[ANGLE_W-1], hi};
        l16 = {lo[ANGLE_W-1], lo};
        t   = '0;
        d   = down;
        if (!d) begin
            t = m16 + c16;
            if (t > h16) begin
                d = 1'b1;
                t = h16;
            end
        end
        if (d) begin
            t = m16 - c16;
            if (t < l16) begin
                d = 1'b0;
                t = l16;
            end
        end
        res.target = t;
        res.down   = d;
        return res;
    endfunction

    // whole-degree magnitude of a command compared with a deadband
    function automatic logic past_deadband(
        input logic signed [ANGLE_W-1:0] cmd,
        input logic [BAND_W-1:0]         band
    );
        logic [ANGLE_W-1:0] mag;
        mag = cmd[ANGLE_W-1] ? (~cmd + 1'b1) : cmd;
        return (mag >> 6) > {{(ANGLE_W-BAND_W){1'b0}}, band};
    endfunction

endpackage

@@ sv/gimbal_setpoint_patrol_generator.sv @@
// gimbal_setpoint_patrol_generator: top level, request register, setpoint logic,
// target state and result register
// depends on gspg_pkg
//
// usage
//   input requests (s_valid/s_ready) carry the mode flags, measured angles
//   and commands for one control tick; each request gives exactly one result
//   on m_valid/m_ready with the new yaw and pitch setpoints and the sweep
//   direction flags after that tick.
//   configuration goes through cfg_we/cfg_index/cfg_wdata, one register per
//   cycle, and should only be written while no request is in flight.
// flow and throughput
//   a request is captured in the input register, then processed into the
//   result register once the result slot is free. one request per cycle
//   is sustained while m_ready stays high; the target and direction state
//   is updated in the same cycle that writes the result.
// reset
//   aresetn (synchronous, active low) empties both stages, zeroes the targets
//   and direction flags and loads the default limits and zero deadbands.
// stall
//   while m_ready is low a held result blocks the processing stage; the
//   input register still takes one more request, then s_ready drops.
module gimbal_setpoint_patrol_generator (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input requests
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_tracking_on,
    input  logic                               s_patrol_on,
    input  logic signed [gspg_pkg::ANGLE_W-1:0] s_yaw_measured,
    input  logic signed [gspg_pkg::ANGLE_W-1:0] s_pitch_measured,
    input  logic signed [gspg_pkg::ANGLE_W-1:0] s_yaw_command,
    input  logic signed [gspg_pkg::ANGLE_W-1:0] s_pitch_command,
    // results
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [gspg_pkg::ANGLE_W-1:0]  m_yaw_setpoint,
    output logic signed [gspg_pkg::TARGET_W-1:0] m_pitch_setpoint,
    output logic                               m_yaw_descending,
    output logic                               m_pitch_descending,
    // configuration
    input  logic                               cfg_we,
    input  logic [gspg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gspg_pkg::ANGLE_W-1:0]       cfg_wdata
);

    // configuration registers
    logic [gspg_pkg::BAND_W-1:0]         yaw_band_reg;
    logic [gspg_pkg::BAND_W-1:0]         pitch_band_reg;
    logic signed [gspg_pkg::ANGLE_W-1:0] pitch_high_free_reg;
    logic signed [gspg_pkg::ANGLE_W-1:0] pitch_low_free_reg;
    logic signed [gspg_pkg::ANGLE_W-1:0] yaw_high_track_reg;
    logic signed [gspg_pkg::ANGLE_W-1:0] yaw_low_track_reg;
    logic signed [gspg_pkg::ANGLE_W-1:0] pitch_high_track_reg;
    logic signed [gspg_pkg::ANGLE_W-1:0] pitch_low_track_reg;

    // input stage
    logic                                in_valid_reg;
    logic                                tracking_reg;
    logic                                patrol_reg;
    logic signed [gspg_pkg::ANGLE_W-1:0] yaw_meas_reg;
    logic signed [gspg_pkg::ANGLE_W-1:0] pitch_meas_reg;
    logic signed [gspg_pkg::ANGLE_W-1:0] yaw_cmd_reg;
    logic signed [gspg_pkg::ANGLE_W-1:0] pitch_cmd_reg;

    // target state
    logic signed [gspg_pkg::TARGET_W-1:0] yaw_target_reg;
    logic signed [gspg_pkg::TARGET_W-1:0] pitch_target_reg;
    logic                                 yaw_down_reg;
    logic                                 pitch_down_reg;
    logic signed [gspg_pkg::TARGET_W-1:0] yaw_target_next;
    logic signed [gspg_pkg::TARGET_W-1:0] pitch_target_next;
    logic                                 yaw_down_next;
    logic                                 pitch_down_next;

    // result stage
    logic                                 out_valid_reg;
    logic signed [gspg_pkg::ANGLE_W-1:0]  yaw_set_reg;
    logic signed [gspg_pkg::TARGET_W-1:0] pitch_set_reg;
    logic                                 yaw_desc_reg;
    logic                                 pitch_desc_reg;

    logic advance;
    logic take_in;

    logic signed [gspg_pkg::TARGET_W-1:0] ym16;
    logic signed [gspg_pkg::TARGET_W-1:0] pm16;
    logic signed [gspg_pkg::TARGET_W-1:0] yc16;
    logic signed [gspg_pkg::TARGET_W-1:0] pc16;
    logic signed [gspg_pkg::TARGET_W-1:0] yaw_raw;
    gspg_pkg::sweep_res_t                 yaw_sw;
    gspg_pkg::sweep_res_t                 pitch_sw;

    // handshake: processing moves when the result slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take_in = s_valid && s_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_band_reg         <= '0;
            pitch_band_reg       <= '0;
            pitch_high_free_reg  <= gspg_pkg::PITCH_HIGH_FREE_RST;
            pitch_low_free_reg   <= gspg_pkg::PITCH_LOW_FREE_RST;
            yaw_high_track_reg   <= gspg_pkg::YAW_HIGH_TRACK_RST;
            yaw_low_track_reg    <= gspg_pkg::YAW_LOW_TRACK_RST;
            pitch_high_track_reg <= gspg_pkg::PITCH_HIGH_TRACK_RST;
            pitch_low_track_reg  <= gspg_pkg::PITCH_LOW_TRACK_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                gspg_pkg::REG_YAW_DEADBAND:
                    yaw_band_reg <= cfg_wdata[gspg_pkg::BAND_W-1:0];
                gspg_pkg::REG_PITCH_DEADBAND:
                    pitch_band_reg <= cfg_wdata[gspg_pkg::BAND_W-1:0];
                gspg_pkg::REG_PITCH_HIGH_FREE:  pitch_high_free_reg  <= cfg_wdata;
                gspg_pkg::REG_PITCH_LOW_FREE:   pitch_low_free_reg   <= cfg_wdata;
                gspg_pkg::REG_YAW_HIGH_TRACK:   yaw_high_track_reg   <= cfg_wdata;
                gspg_pkg::REG_YAW_LOW_TRACK:    yaw_low_track_reg    <= cfg_wdata;
                gspg_pkg::REG_PITCH_HIGH_TRACK: pitch_high_track_reg <= cfg_wdata;
                gspg_pkg::REG_PITCH_LOW_TRACK:  pitch_low_track_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (take_in) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            tracking_reg   <= s_tracking_on;
            patrol_reg     <= s_patrol_on;
            yaw_meas_reg   <= s_yaw_measured;
            pitch_meas_reg <= s_pitch_measured;
            yaw_cmd_reg    <= s_yaw_command;
            pitch_cmd_reg  <= s_pitch_command;
        end
    end

    // setpoint logic
    always_comb begin
        ym16 = {yaw_meas_reg[gspg_pkg::ANGLE_W-1], yaw_meas_reg};
        pm16 = {pitch_meas_reg[gspg_pkg::ANGLE_W-1], pitch_meas_reg};
        yc16 = {yaw_cmd_reg[gspg_pkg::ANGLE_W-1], yaw_cmd_reg};
        pc16 = {pitch_cmd_reg[gspg_pkg::ANGLE_W-1], pitch_cmd_reg};

        yaw_sw = gspg_pkg::sweep(yaw_meas_reg, yaw_cmd_reg, yaw_high_track_reg,
                                 yaw_low_track_reg, yaw_down_reg);
        if (tracking_reg) begin
            pitch_sw = gspg_pkg::sweep(pitch_meas_reg, pitch_cmd_reg,
                                       pitch_high_track_reg, pitch_low_track_reg,
                                       pitch_down_reg);
        end else begin
            pitch_sw = gspg_pkg::sweep(pitch_meas_reg, pitch_cmd_reg,
                                       pitch_high_free_reg, pitch_low_free_reg,
                                       pitch_down_reg);
        end

        yaw_raw           = yaw_target_reg;
        pitch_target_next = pitch_target_reg;
        yaw_down_next     = yaw_down_reg;
        pitch_down_next   = pitch_down_reg;

        if (!tracking_reg) begin
            if (patrol_reg) begin
                yaw_raw           = ym16 - yc16;
                pitch_target_next = pitch_sw.target;
                pitch_down_next   = pitch_sw.down;
            end else begin
                if (gspg_pkg::past_deadband(yaw_cmd_reg, yaw_band_reg)) begin
                    yaw_raw = ym16 - yc16;
                end
                if (gspg_pkg::past_deadband(pitch_cmd_reg, pitch_band_reg)) begin
                    pitch_target_next = pm16 + pc16;
                end
            end
        end else begin
            if (patrol_reg) begin
                yaw_raw           = yaw_sw.target;
                yaw_down_next     = yaw_sw.down;
                pitch_target_next = pitch_sw.target;
                pitch_down_next   = pitch_sw.down;
            end else begin
                yaw_raw           = yc16;
                pitch_target_next = pc16;
            end
        end

        // yaw wrap, one full-turn correction
        if (yaw_raw > gspg_pkg::HALF_TURN) begin
            yaw_target_next = yaw_raw - gspg_pkg::FULL_TURN;
        end else if (yaw_raw < -gspg_pkg::HALF_TURN) begin
            yaw_target_next = yaw_raw + gspg_pkg::FULL_TURN;
        end else begin
            yaw_target_next = yaw_raw;
        end
    end

    // target state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_target_reg   <= '0;
            pitch_target_reg <= '0;
            yaw_down_reg     <= 1'b0;
            pitch_down_reg   <= 1'b0;
        end else if (advance) begin
            yaw_target_reg   <= yaw_target_next;
            pitch_target_reg <= pitch_target_next;
            yaw_down_reg     <= yaw_down_next;
            pitch_down_reg   <= pitch_down_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            yaw_set_reg    <= yaw_target_next[gspg_pkg::ANGLE_W-1:0];
            pitch_set_reg  <= pitch_target_next;
            yaw_desc_reg   <= yaw_down_next;
            pitch_desc_reg <= pitch_down_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_yaw_setpoint     = yaw_set_reg;
    assign m_pitch_setpoint   = pitch_set_reg;
    assign m_yaw_descending   = yaw_desc_reg;
    assign m_pitch_descending = pitch_desc_reg;

endmodule

@@ tb/sv/gimbal_setpoint_patrol_generator_tb.sv @@
// gimbal_setpoint_patrol_generator_tb: self-checking testbench for the gimbal
// setpoint patrol generator, with its own target predictor and result scoreboard
// depends on gspg_pkg and gimbal_setpoint_patrol_generator
module gimbal_setpoint_patrol_generator_tb;

    localparam int ANGLE_W   = gspg_pkg::ANGLE_W;
    localparam int TARGET_W  = gspg_pkg::TARGET_W;
    localparam int BAND_W    = gspg_pkg::BAND_W;
    localparam int CFG_IDX_W = gspg_pkg::CFG_IDX_W;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 10;

    // one expected result
    typedef struct packed {
        logic signed [ANGLE_W-1:0]  yaw;
        logic signed [TARGET_W-1:0] pitch;
        logic                       yaw_down;
        logic                       pitch_down;
    } setpoint_t;

    // predicts the new targets for each request and checks the results in order
    class setpoint_scoreboard;
        int yaw_band;
        int pitch_band;
        int pitch_hi_free;
        int pitch_lo_free;
        int yaw_hi_track;
        int yaw_lo_track;
        int pitch_hi_track;
        int pitch_lo_track;
        // targets always fit 16 bits, kept as int for exact sums
        int yaw_t;
        int pitch_t;
        bit yaw_down;
        bit pitch_down;
        setpoint_t setpoint_due[$];
        int errors;
        int checked;

        function new();
            yaw_band       = 0;
            pitch_band     = 0;
            pitch_hi_free  = gspg_pkg::PITCH_HIGH_FREE_RST;
            pitch_lo_free  = gspg_pkg::PITCH_LOW_FREE_RST;
            yaw_hi_track   = gspg_pkg::YAW_HIGH_TRACK_RST;
            yaw_lo_track   = gspg_pkg::YAW_LOW_TRACK_RST;
            pitch_hi_track = gspg_pkg::PITCH_HIGH_TRACK_RST;
            pitch_lo_track = gspg_pkg::PITCH_LOW_TRACK_RST;
            yaw_t          = 0;
            pitch_t        = 0;
            yaw_down       = 1'b0;
            pitch_down     = 1'b0;
            errors         = 0;
            checked        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ANGLE_W-1:0] data);
            case (idx)
                gspg_pkg::REG_YAW_DEADBAND:     yaw_band       = data[BAND_W-1:0];
                gspg_pkg::REG_PITCH_DEADBAND:   pitch_band     = data[BAND_W-1:0];
                gspg_pkg::REG_PITCH_HIGH_FREE:  pitch_hi_free  = $signed(data);
                gspg_pkg::REG_PITCH_LOW_FREE:   pitch_lo_free  = $signed(data);
                gspg_pkg::REG_YAW_HIGH_TRACK:   yaw_hi_track   = $signed(data);
                gspg_pkg::REG_YAW_LOW_TRACK:    yaw_lo_track   = $signed(data);
                gspg_pkg::REG_PITCH_HIGH_TRACK: pitch_hi_track = $signed(data);
                gspg_pkg::REG_PITCH_LOW_TRACK:  pitch_lo_track = $signed(data);
                default: ;
            endcase
        endfunction

        // whole degrees of the command strictly above the band
        function bit beyond_band(int cmd, int band);
            int mag;
            mag = (cmd < 0) ? -cmd : cmd;
            return (mag >> 6) > band;
        endfunction

        // rise check first, then the fall check sees a freshly set flag
        function int sweep_axis(input int meas, input int cmd, input int hi, input int lo,
                                inout bit down);
            int t;
            t = 0;
            if (!down) begin
                t = meas + cmd;
                if (t > hi) begin
                    down = 1'b1;
                    t    = hi;
                end
            end
            if (down) begin
                t = meas - cmd;
                if (t < lo) begin
                    down = 1'b0;
                    t    = lo;
                end
            end
            return t;
        endfunction

        // advance the targets for one accepted request and queue the result
        function void note_request(logic trk, logic pat,
                                   logic signed [ANGLE_W-1:0] ym_i,
                                   logic signed [ANGLE_W-1:0] pm_i,
                                   logic signed [ANGLE_W-1:0] yc_i,
                                   logic signed [ANGLE_W-1:0] pc_i);
            int ym;
            int pm;
            int yc;
            int pc;
            setpoint_t e;
            ym = ym_i;
            pm = pm_i;
            yc = yc_i;
            pc = pc_i;
            if (!trk) begin
                if (pat) begin
                    yaw_t   = ym - yc;
                    pitch_t = sweep_axis(pm, pc, pitch_hi_free, pitch_lo_free, pitch_down);
                end else begin
                    if (beyond_band(yc, yaw_band))
                        yaw_t = ym - yc;
                    if (beyond_band(pc, pitch_band))
                        pitch_t = pm + pc;
                end
            end else if (pat) begin
                yaw_t   = sweep_axis(ym, yc, yaw_hi_track, yaw_lo_track, yaw_down);
                pitch_t = sweep_axis(pm, pc, pitch_hi_track, pitch_lo_track, pitch_down);
            end else begin
                yaw_t   = yc;
                pitch_t = pc;
            end
            // single 360 degree correction
            if (yaw_t > int'(gspg_pkg::HALF_TURN))
                yaw_t -= int'(gspg_pkg::FULL_TURN);
            if (yaw_t < -int'(gspg_pkg::HALF_TURN))
                yaw_t += int'(gspg_pkg::FULL_TURN);
            e.yaw        = yaw_t[ANGLE_W-1:0];
            e.pitch      = pitch_t[TARGET_W-1:0];
            e.yaw_down   = yaw_down;
            e.pitch_down = pitch_down;
            setpoint_due.push_back(e);
        endfunction

        function void compare_field(string what, logic signed [TARGET_W-1:0] expv,
                                    logic signed [TARGET_W-1:0] actv);
            if (actv !== expv) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, expv, actv);
            end
        endfunction

        function void check_result(logic signed [ANGLE_W-1:0] yaw,
                                   logic signed [TARGET_W-1:0] pitch,
                                   logic yd, logic pd);
            setpoint_t e;
            if (setpoint_due.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding: expected none, actual yaw %0d pitch %0d",
                         $time, yaw, pitch);
                return;
            end
            e = setpoint_due.pop_front();
            checked++;
            compare_field("yaw_setpoint", e.yaw, yaw);
            compare_field("pitch_setpoint", e.pitch, pitch);
            compare_field("yaw_descending", e.yaw_down, yd);
            compare_field("pitch_descending", e.pitch_down, pd);
        endfunction

        function void flush_leftover();
            if (setpoint_due.size() != 0) begin
                errors += setpoint_due.size();
                $display("%0t: results missing: expected %0d more, actual 0",
                         $time, setpoint_due.size());
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic s_tracking_on;
    logic s_patrol_on;
    logic signed [ANGLE_W-1:0]  s_yaw_measured;
    logic signed [ANGLE_W-1:0]  s_pitch_measured;
    logic signed [ANGLE_W-1:0]  s_yaw_command;
    logic signed [ANGLE_W-1:0]  s_pitch_command;
    logic m_valid;
    logic m_ready;
    logic signed [ANGLE_W-1:0]  m_yaw_setpoint;
    logic signed [TARGET_W-1:0] m_pitch_setpoint;
    logic m_yaw_descending;
    logic m_pitch_descending;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ANGLE_W-1:0]   cfg_wdata;

    setpoint_scoreboard sb;
    logic [ANGLE_W-1:0] reg_image [8];
    int tx_idle_pct = 23;
    int rx_idle_pct = 23;
    int stall_req = 0;
    int stall_seen = 0;
    int requests_taken = 0;
    int settings_used = 0;
    int cycle_count = 0;

    gimbal_setpoint_patrol_generator dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_tracking_on      (s_tracking_on),
        .s_patrol_on        (s_patrol_on),
        .s_yaw_measured     (s_yaw_measured),
        .s_pitch_measured   (s_pitch_measured),
        .s_yaw_command      (s_yaw_command),
        .s_pitch_command    (s_pitch_command),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_yaw_setpoint     (m_yaw_setpoint),
        .m_pitch_setpoint   (m_pitch_setpoint),
        .m_yaw_descending   (m_yaw_descending),
        .m_pitch_descending (m_pitch_descending),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // watch both channels and the register port
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_yaw_setpoint, m_pitch_setpoint,
                                m_yaw_descending, m_pitch_descending);
            if (s_valid && s_ready) begin
                sb.note_request(s_tracking_on, s_patrol_on, s_yaw_measured,
                                s_pitch_measured, s_yaw_command, s_pitch_command);
                requests_taken++;
            end
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_wdata);
        end
    end

    // result side: random ready, long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_seen != stall_req) begin
                stall_seen++;
                m_ready <= 1'b0;
                for (int n = 1; n < RX_HOLD_CYCLES; n++)
                    @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic signed [ANGLE_W-1:0] rand_angle();
        int v;
        case ($urandom_range(9))
            0: v = $urandom;
            1: begin
                case ($urandom_range(5))
                    0: v = -16384;
                    1: v = 16383;
                    2: v = -int'(gspg_pkg::HALF_TURN);
                    3: v = int'(gspg_pkg::HALF_TURN);
                    4: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = int'($urandom_range(2 * gspg_pkg::HALF_TURN))
                         - int'(gspg_pkg::HALF_TURN);
        endcase
        return v[ANGLE_W-1:0];
    endfunction

    // mostly small sweep steps, now and then anything
    function automatic logic signed [ANGLE_W-1:0] small_step();
        int c;
        if ($urandom_range(9) == 0)
            return rand_angle();
        c = $urandom_range(300);
        if ($urandom_range(7) == 0)
            c = -c;
        return c[ANGLE_W-1:0];
    endfunction

    // command whose whole-degree size lands on either side of the band
    function automatic logic signed [ANGLE_W-1:0] near_band(int band);
        int mag;
        int v;
        if ($urandom_range(3) == 0)
            return rand_angle();
        mag = (band + 1) * 64 + int'($urandom_range(127)) - 64;
        if ($urandom_range(1)) begin
            if (mag > 16384)
                mag = 16384;
            v = -mag;
        end else begin
            if (mag > 16383)
                mag = 16383;
            v = mag;
        end
        return v[ANGLE_W-1:0];
    endfunction

    // measured angle walking back and forth a little past both limits
    function automatic logic signed [ANGLE_W-1:0] walk_angle(inout int pos, inout int dir,
                                                             input int a, input int b);
        int top;
        int bot;
        int span;
        int v;
        top  = ((a > b) ? a : b) + 400;
        bot  = ((a < b) ? a : b) - 400;
        span = top - bot;
        pos += dir * (span / 12 + int'($urandom_range(span / 12)) + 1);
        if (pos >= top) begin
            pos = top;
            dir = -1;
        end else if (pos <= bot) begin
            pos = bot;
            dir = 1;
        end
        v = (pos > 16383) ? 16383 : (pos < -16384) ? -16384 : pos;
        return v[ANGLE_W-1:0];
    endfunction

    function automatic void pick_limits(logic [CFG_IDX_W-1:0] hi_idx,
                                        logic [CFG_IDX_W-1:0] lo_idx);
        int lo;
        int hi;
        int t;
        lo = int'($urandom_range(22000)) - int'(gspg_pkg::HALF_TURN);
        hi = lo + 64 + int'($urandom_range(8000));
        if (hi > int'(gspg_pkg::HALF_TURN))
            hi = int'(gspg_pkg::HALF_TURN);
        // crossed limits now and then
        if ($urandom_range(4) == 0) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        reg_image[hi_idx] = hi[ANGLE_W-1:0];
        reg_image[lo_idx] = lo[ANGLE_W-1:0];
    endfunction

    // offer one request and hold it until taken, then maybe idle
    task automatic send_tick(input logic trk, input logic pat,
                             input logic signed [ANGLE_W-1:0] ym,
                             input logic signed [ANGLE_W-1:0] pm,
                             input logic signed [ANGLE_W-1:0] yc,
                             input logic signed [ANGLE_W-1:0] pc);
        s_valid          <= 1'b1;
        s_tracking_on    <= trk;
        s_patrol_on      <= pat;
        s_yaw_measured   <= ym;
        s_pitch_measured <= pm;
        s_yaw_command    <= yc;
        s_pitch_command  <= pc;
        do @(posedge aclk); while (!s_ready);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain(input int settle);
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.setpoint_due.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    // write all eight registers from the image, one per cycle
    task automatic program_settings();
        for (int i = gspg_pkg::REG_YAW_DEADBAND; i <= gspg_pkg::REG_PITCH_LOW_TRACK; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= reg_image[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    // random mix of patrol sweeps, deadband checks, direct copies and noise
    task automatic run_sequences(input int n_items);
        int sent;
        int len;
        int kind;
        int py;
        int dy;
        int pp;
        int dp;
        int y_hi;
        int y_lo;
        int p_hi;
        int p_lo;
        logic trk;
        logic pat;
        logic signed [ANGLE_W-1:0] ym;
        logic signed [ANGLE_W-1:0] pm;
        logic signed [ANGLE_W-1:0] yc;
        logic signed [ANGLE_W-1:0] pc;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(9);
            trk  = $urandom_range(1);
            y_hi = sb.yaw_hi_track;
            y_lo = sb.yaw_lo_track;
            p_hi = trk ? sb.pitch_hi_track : sb.pitch_hi_free;
            p_lo = trk ? sb.pitch_lo_track : sb.pitch_lo_free;
            py   = (y_hi + y_lo) / 2;
            pp   = (p_hi + p_lo) / 2;
            dy   = $urandom_range(1) ? 1 : -1;
            dp   = $urandom_range(1) ? 1 : -1;
            len  = (kind < 5) ? $urandom_range(20, 60) : $urandom_range(4, 16);
            for (int k = 0; k < len && sent < n_items; k++) begin
                if (kind < 5) begin
                    // patrol sweep
                    pat = 1'b1;
                    pm  = walk_angle(pp, dp, p_hi, p_lo);
                    pc  = small_step();
                    if (trk) begin
                        ym = walk_angle(py, dy, y_hi, y_lo);
                        yc = small_step();
                    end else begin
                        ym = rand_angle();
                        yc = rand_angle();
                    end
                end else if (kind < 7) begin
                    // free mode around the deadbands
                    trk = 1'b0;
                    pat = 1'b0;
                    ym  = rand_angle();
                    pm  = rand_angle();
                    yc  = near_band(sb.yaw_band);
                    pc  = near_band(sb.pitch_band);
                end else if (kind == 7) begin
                    // tracking without patrol copies commands
                    trk = 1'b1;
                    pat = 1'b0;
                    ym  = rand_angle();
                    pm  = rand_angle();
                    yc  = rand_angle();
                    pc  = rand_angle();
                end else begin
                    // raw bits
                    trk = $urandom_range(1);
                    pat = $urandom_range(1);
                    ym  = ANGLE_W'($urandom);
                    pm  = ANGLE_W'($urandom);
                    yc  = ANGLE_W'($urandom);
                    pc  = ANGLE_W'($urandom);
                end
                send_tick(trk, pat, ym, pm, yc, pc);
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_tracking_on    <= 1'b0;
        s_patrol_on      <= 1'b0;
        s_yaw_measured   <= '0;
        s_pitch_measured <= '0;
        s_yaw_command    <= '0;
        s_pitch_command  <= '0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_wdata        <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed requests on the reset settings
        send_tick(0, 0, 0, 0, 0, 0);                  // zero command held
        send_tick(0, 0, 100, 200, 64, 64);            // one degree passes
        send_tick(0, 0, 300, 300, 63, -63);           // just under one degree held
        send_tick(0, 0, 0, 0, -64, -64);
        send_tick(0, 0, 11520, 11520, -11520, 11520); // +360 wraps to zero
        send_tick(0, 0, -11520, -11520, 11520, -11520);
        send_tick(0, 0, 16383, 16383, -16384, 16383); // widest sums
        send_tick(0, 0, -16384, -16384, 16383, -16384);
        send_tick(0, 0, 11520, 0, -64, 0);            // just past +180
        send_tick(0, 0, -11520, 0, 64, 0);            // just past -180
        send_tick(0, 0, 11456, 0, -64, 0);            // exactly +180 kept
        send_tick(1, 0, 0, 0, -16384, 16383);         // commands copied
        send_tick(1, 0, 0, 0, 11520, -11520);
        send_tick(0, 1, 500, 2200, 100, 100);         // pitch reaches high, turns down
        send_tick(0, 1, 500, 600, 100, 50);           // pitch reaches low, turns up
        send_tick(0, 1, 0, 1500, 0, 1000);            // both limits in one tick
        send_tick(1, 1, 5000, 2500, 500, 100);        // yaw and pitch turn down
        send_tick(1, 1, 4000, 2000, 300, 100);
        send_tick(1, 1, -1000, 300, 400, 100);        // both back up at low
        send_tick(1, 1, -16384, -16384, 16383, 16383);
        send_tick(1, 1, 16383, 16383, -16384, -16384);
        send_tick(0, 1, -16384, 0, 16383, 0);
        send_tick(1, 0, 0, 0, 0, 0);

        for (int ph = 0; ph < 6; ph++) begin
            drain(SETTLE_CYCLES);
            case (ph)
                0: ;
                1: begin
                    reg_image[gspg_pkg::REG_YAW_DEADBAND]     = 180;
                    reg_image[gspg_pkg::REG_PITCH_DEADBAND]   = 255;
                    reg_image[gspg_pkg::REG_PITCH_HIGH_FREE]  = ANGLE_W'(gspg_pkg::HALF_TURN);
                    reg_image[gspg_pkg::REG_PITCH_LOW_FREE]   = ANGLE_W'(-gspg_pkg::HALF_TURN);
                    reg_image[gspg_pkg::REG_YAW_HIGH_TRACK]   = ANGLE_W'(gspg_pkg::HALF_TURN);
                    reg_image[gspg_pkg::REG_YAW_LOW_TRACK]    = ANGLE_W'(-gspg_pkg::HALF_TURN);
                    reg_image[gspg_pkg::REG_PITCH_HIGH_TRACK] = ANGLE_W'(gspg_pkg::HALF_TURN);
                    reg_image[gspg_pkg::REG_PITCH_LOW_TRACK]  = ANGLE_W'(-gspg_pkg::HALF_TURN);
                end
                2: begin
                    // zero bands with the unused upper bits set, crossed limits
                    reg_image[gspg_pkg::REG_YAW_DEADBAND]     = 15'h7F00;
                    reg_image[gspg_pkg::REG_PITCH_DEADBAND]   = 15'h7F00;
                    reg_image[gspg_pkg::REG_PITCH_HIGH_FREE]  = -640;
                    reg_image[gspg_pkg::REG_PITCH_LOW_FREE]   = 640;
                    reg_image[gspg_pkg::REG_YAW_HIGH_TRACK]   = -1000;
                    reg_image[gspg_pkg::REG_YAW_LOW_TRACK]    = 2000;
                    reg_image[gspg_pkg::REG_PITCH_HIGH_TRACK] = 100;
                    reg_image[gspg_pkg::REG_PITCH_LOW_TRACK]  = 300;
                end
                4: begin
                    // full register width
                    reg_image[gspg_pkg::REG_YAW_DEADBAND]     = 15'h7FFF;
                    reg_image[gspg_pkg::REG_PITCH_DEADBAND]   = 15'h00FF;
                    reg_image[gspg_pkg::REG_PITCH_HIGH_FREE]  = 16383;
                    reg_image[gspg_pkg::REG_PITCH_LOW_FREE]   = -16384;
                    reg_image[gspg_pkg::REG_YAW_HIGH_TRACK]   = 16383;
                    reg_image[gspg_pkg::REG_YAW_LOW_TRACK]    = -16384;
                    reg_image[gspg_pkg::REG_PITCH_HIGH_TRACK] = 16383;
                    reg_image[gspg_pkg::REG_PITCH_LOW_TRACK]  = -16384;
                end
                default: begin
                    reg_image[gspg_pkg::REG_YAW_DEADBAND] =
                        ANGLE_W'($urandom_range(180)) | ANGLE_W'($urandom_range(127) << 8);
                    reg_image[gspg_pkg::REG_PITCH_DEADBAND] =
                        ANGLE_W'($urandom_range(180)) | ANGLE_W'($urandom_range(127) << 8);
                    pick_limits(gspg_pkg::REG_PITCH_HIGH_FREE, gspg_pkg::REG_PITCH_LOW_FREE);
                    pick_limits(gspg_pkg::REG_YAW_HIGH_TRACK, gspg_pkg::REG_YAW_LOW_TRACK);
                    pick_limits(gspg_pkg::REG_PITCH_HIGH_TRACK, gspg_pkg::REG_PITCH_LOW_TRACK);
                end
            endcase
            if (ph != 0)
                program_settings();
            case (ph)
                1: begin
                    // receiver holds off while requests keep coming
                    tx_idle_pct = 0;
                    stall_req++;
                    run_sequences(40);
                    tx_idle_pct = 23;
                    run_sequences(140);
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    run_sequences(180);
                    tx_idle_pct = 23;
                    rx_idle_pct = 23;
                end
                3: begin
                    run_sequences(90);
                    drain(0);
                    run_sequences(90);
                end
                default: run_sequences(180);
            endcase
        end

        drain(END_CYCLES);
        sb.flush_leftover();
        $display("covered %0d requests and %0d results over %0d register settings",
                 requests_taken, sb.checked, settings_used + 1);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
sv/gspg_pkg.sv
sv/gimbal_setpoint_patrol_generator.sv
tb/sv/gimbal_setpoint_patrol_generator_tb.sv
